// File: src/tsft_pkg.sv
// ----------------------------------------------------------------------------
// tsft_pkg
// shared types and constants of the syn flood / slowloris tracker
// ----------------------------------------------------------------------------
package tsft_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_SYN_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN_WINDOW        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_EVICT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLISION_EVICT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_TIMEOUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HTTP_PORT         = 3'd5;

  // register reset values
  localparam logic [15:0] RST_SYN_THRESHOLD   = 16'd100;
  localparam logic [30:0] RST_SYN_WINDOW      = 31'd1000;
  localparam logic [30:0] RST_IDLE_EVICT      = 31'd60000;
  localparam logic [30:0] RST_COLLISION_EVICT = 31'd5000;
  localparam logic [30:0] RST_HEADER_TIMEOUT  = 31'd30000;
  localparam logic [15:0] RST_HTTP_PORT       = 16'd80;

  // event codes
  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_SYN_FLOOD = 2'd1;
  localparam logic [1:0] EV_SLOWLORIS = 2'd2;

  // one table entry
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seen_at;
    logic [31:0] window_start;
    logic [31:0] syn_cnt;
    logic [31:0] header_start;
    logic        blocked;
  } slot_t;

  // key handed to the hash unit
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
  } hsh_key_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK,
    S_UPDATE
  } tsft_state_t;

  // a is after b when (b - a) is negative as a signed 32-bit value
  function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d[31];
  endfunction

endpackage

// File: src/tcp_syn_flood_slowloris_tracker_core.sv
// ----------------------------------------------------------------------------
// tcp_syn_flood_slowloris_tracker_core
// per-source syn flood counter and slowloris header timer over a slot table
// ----------------------------------------------------------------------------
// usage
//   - a packet word is taken at the clock edge where start is high and busy
//     is low; all in_* fields are sampled at that edge
//   - exactly one result word per packet appears on the out_* ports for one
//     cycle, marked by out_valid; the receiver cannot stall, so the result
//     is simply gone after that cycle
//   - a packet passes the hash, with the table read issued as it ends, then
//     the claim check, then the update and write back, then idle, where the
//     next word is taken; a table size that is not a power of two adds the
//     reciprocal remainder stages to the hash; busy holds off a new word
//   - out_valid rises as the sequencer leaves the update for idle; busy
//     falls in that same cycle
//   - one packet is in flight at a time, so the write back always lands
//     before the next table read and no forwarding is needed
//   - after reset all TABLE_ENTRIES entries (4096 by default) are swept to
//     zero, one entry a cycle; busy stays high meanwhile
//   - the cfg port is a plain write port, taken in any cycle, including
//     during the sweep; it is meant to be written only while idle
// ----------------------------------------------------------------------------
module tcp_syn_flood_slowloris_tracker_core #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tsft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsft_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // packet in
  input  logic                                start,
  output logic                                busy,
  input  logic [31:0]                         in_src_ip,
  input  logic [31:0]                         in_dest_ip,
  input  logic [15:0]                         in_src_port,
  input  logic [15:0]                         in_dest_port,
  input  logic                                in_syn_flag,
  input  logic                                in_ack_flag,
  input  logic [31:0]                         in_now_ticks,
  // verdict out
  output logic                                out_valid,
  output logic                                out_drop,
  output logic                                out_bypassed,
  output logic [1:0]                          out_event_kind,
  output logic [31:0]                         out_event_src_ip,
  output logic [31:0]                         out_event_dest_ip,
  output logic [15:0]                         out_event_src_port,
  output logic [15:0]                         out_event_dest_port,
  output logic [31:0]                         out_syn_rate
);
  import tsft_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  // configuration registers
  logic [15:0] thr_r;
  logic [30:0] win_r;
  logic [30:0] idle_r;
  logic [30:0] coll_r;
  logic [30:0] hto_r;
  logic [15:0] http_r;

  // sequencer
  tsft_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // packet held for the whole lookup
  logic [31:0] pkt_sip_r;
  logic [31:0] pkt_dip_r;
  logic [15:0] pkt_sport_r;
  logic [15:0] pkt_dport_r;
  logic        pkt_syn_r;
  logic        pkt_ack_r;
  logic [31:0] pkt_now_r;

  // slot after the claim decision
  slot_t eff_r, eff_nxt;
  logic  bypass_r, bypass_nxt;

  // table memory
  slot_t            slot_mem [TABLE_ENTRIES];
  slot_t            rd_slot_r;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;

  // hash unit
  logic             hsh_start;
  hsh_key_t         hsh_key;
  logic             hsh_done;
  logic [IDX_W-1:0] hsh_idx;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic        out_drop_r, out_drop_nxt;
  logic        out_bypassed_r, out_bypassed_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [31:0] out_sip_r, out_sip_nxt;
  logic [31:0] out_dip_r, out_dip_nxt;
  logic [15:0] out_sport_r, out_sport_nxt;
  logic [15:0] out_dport_r, out_dport_nxt;
  logic [31:0] out_rate_r, out_rate_nxt;

  // claim check
  logic  chk_match;
  logic  chk_claim;
  logic  chk_bypass;
  slot_t chk_slot;

  // update
  slot_t       upd_slot;
  logic        upd_drop;
  logic [1:0]  upd_kind;
  logic [31:0] upd_rate;
  logic [31:0] cnt_inc;
  logic [31:0] hdr_cur;
  logic        win_exp;
  logic        over_thr;
  logic        first_over;
  logic        hdr_exp;

  // --------------------------------------------------------------------------
  // configuration writes; unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= RST_SYN_THRESHOLD;
      win_r  <= RST_SYN_WINDOW;
      idle_r <= RST_IDLE_EVICT;
      coll_r <= RST_COLLISION_EVICT;
      hto_r  <= RST_HEADER_TIMEOUT;
      http_r <= RST_HTTP_PORT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYN_THRESHOLD:   thr_r  <= cfg_wdata[15:0];
        CFG_SYN_WINDOW:      win_r  <= cfg_wdata;
        CFG_IDLE_EVICT:      idle_r <= cfg_wdata;
        CFG_COLLISION_EVICT: coll_r <= cfg_wdata;
        CFG_HEADER_TIMEOUT:  hto_r  <= cfg_wdata;
        CFG_HTTP_PORT:       http_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // slot index: hash starts straight from the input ports on accept
  // --------------------------------------------------------------------------
  assign hsh_key = '{addr: in_src_ip, port: in_src_port};

  tsft_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hsh_start),
    .key   (hsh_key),
    .done  (hsh_done),
    .idx   (hsh_idx)
  );

  // --------------------------------------------------------------------------
  // table memory, one read port and one write port, registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_slot_r <= slot_mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // claim check: same key keeps the slot, an empty or stale slot is taken
  // over, anything else passes untracked
  // --------------------------------------------------------------------------
  always_comb begin
    chk_match  = (rd_slot_r.addr == pkt_sip_r) && (rd_slot_r.port == pkt_sport_r);
    chk_claim  = !chk_match &&
                 ((rd_slot_r.addr == 32'd0) ||
                  later_than(pkt_now_r, rd_slot_r.seen_at + {1'b0, idle_r}) ||
                  later_than(pkt_now_r, rd_slot_r.seen_at + {1'b0, coll_r}));
    chk_bypass = !chk_match && !chk_claim;
    if (chk_claim) begin
      chk_slot = '{addr:         pkt_sip_r,
                   port:         pkt_sport_r,
                   seen_at:      pkt_now_r,
                   window_start: pkt_now_r,
                   syn_cnt:      32'd0,
                   header_start: 32'd0,
                   blocked:      1'b0};
    end else begin
      chk_slot = rd_slot_r;
    end
  end

  // --------------------------------------------------------------------------
  // update: syn window counting, block on threshold, header timer
  // --------------------------------------------------------------------------
  always_comb begin
    upd_slot         = eff_r;
    upd_slot.seen_at = pkt_now_r;
    upd_drop         = 1'b0;
    upd_kind         = EV_NONE;
    upd_rate         = 32'd0;

    // saturating count
    cnt_inc    = (eff_r.syn_cnt == 32'hFFFF_FFFF) ? eff_r.syn_cnt
                                                  : eff_r.syn_cnt + 32'd1;
    win_exp    = later_than(pkt_now_r, eff_r.window_start + {1'b0, win_r});
    over_thr   = cnt_inc > {16'd0, thr_r};
    first_over = cnt_inc == ({16'd0, thr_r} + 32'd1);

    // bare syn only
    if (pkt_syn_r && !pkt_ack_r) begin
      if (win_exp) begin
        upd_slot.syn_cnt      = 32'd1;
        upd_slot.window_start = pkt_now_r;
      end else begin
        upd_slot.syn_cnt = cnt_inc;
        if (over_thr) begin
          upd_slot.blocked = 1'b1;
          upd_drop         = 1'b1;
          if (first_over) begin
            upd_kind = EV_SYN_FLOOD;
            upd_rate = cnt_inc;
          end
        end
      end
    end

    // a start time of zero reads as not started
    hdr_cur = (eff_r.header_start == 32'd0) ? pkt_now_r : eff_r.header_start;
    hdr_exp = later_than(pkt_now_r, hdr_cur + {1'b0, hto_r});

    if (upd_slot.blocked) begin
      upd_drop = 1'b1;
    end else if (pkt_dport_r == http_r) begin
      upd_slot.header_start = hdr_cur;
      if (hdr_exp) begin
        upd_drop         = 1'b1;
        upd_slot.blocked = 1'b1;
        upd_kind         = EV_SLOWLORIS;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    clr_idx_nxt      = clr_idx_r;
    idx_nxt          = idx_r;
    eff_nxt          = eff_r;
    bypass_nxt       = bypass_r;
    hsh_start        = 1'b0;
    mem_re           = 1'b0;
    mem_raddr        = hsh_idx;
    mem_we           = 1'b0;
    mem_waddr        = idx_r;
    mem_wdata        = upd_slot;
    out_valid_nxt    = 1'b0;
    out_drop_nxt     = out_drop_r;
    out_bypassed_nxt = out_bypassed_r;
    out_kind_nxt     = out_kind_r;
    out_sip_nxt      = out_sip_r;
    out_dip_nxt      = out_dip_r;
    out_sport_nxt    = out_sport_r;
    out_dport_nxt    = out_dport_r;
    out_rate_nxt     = out_rate_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          hsh_start = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hsh_done) begin
          mem_re    = 1'b1;
          idx_nxt   = hsh_idx;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        eff_nxt    = chk_slot;
        bypass_nxt = chk_bypass;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        // a bypassed packet leaves the slot untouched
        mem_we           = !bypass_r;
        out_valid_nxt    = 1'b1;
        out_bypassed_nxt = bypass_r;
        out_drop_nxt     = bypass_r ? 1'b0 : upd_drop;
        out_kind_nxt     = bypass_r ? EV_NONE : upd_kind;
        out_rate_nxt     = bypass_r ? 32'd0 : upd_rate;
        if (!bypass_r && (upd_kind != EV_NONE)) begin
          out_sip_nxt   = pkt_sip_r;
          out_dip_nxt   = pkt_dip_r;
          out_sport_nxt = pkt_sport_r;
          out_dport_nxt = pkt_dport_r;
        end else begin
          out_sip_nxt   = 32'd0;
          out_dip_nxt   = 32'd0;
          out_sport_nxt = 16'd0;
          out_dport_nxt = 16'd0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      pkt_sip_r   <= in_src_ip;
      pkt_dip_r   <= in_dest_ip;
      pkt_sport_r <= in_src_port;
      pkt_dport_r <= in_dest_port;
      pkt_syn_r   <= in_syn_flag;
      pkt_ack_r   <= in_ack_flag;
      pkt_now_r   <= in_now_ticks;
    end
    idx_r          <= idx_nxt;
    eff_r          <= eff_nxt;
    bypass_r       <= bypass_nxt;
    out_drop_r     <= out_drop_nxt;
    out_bypassed_r <= out_bypassed_nxt;
    out_kind_r     <= out_kind_nxt;
    out_sip_r      <= out_sip_nxt;
    out_dip_r      <= out_dip_nxt;
    out_sport_r    <= out_sport_nxt;
    out_dport_r    <= out_dport_nxt;
    out_rate_r     <= out_rate_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_drop            = out_drop_r;
  assign out_bypassed        = out_bypassed_r;
  assign out_event_kind      = out_kind_r;
  assign out_event_src_ip    = out_sip_r;
  assign out_event_dest_ip   = out_dip_r;
  assign out_event_src_port  = out_sport_r;
  assign out_event_dest_port = out_dport_r;
  assign out_syn_rate        = out_rate_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_UPDATE))
    else $error("result strobe without an update cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == S_HASH))
    else $error("accepted packet did not start a lookup");

  a_bypass_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bypassed) |-> (!out_drop && out_event_kind == EV_NONE))
    else $error("bypassed packet dropped or raised an event");

  a_event_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != EV_NONE) |-> out_drop)
    else $error("event raised on a packet that passes");

  a_rate_only_flood: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_syn_rate != 32'd0) |-> (out_event_kind == EV_SYN_FLOOD))
    else $error("syn rate reported without a flood event");

endmodule

// File: src/tsft_hash.sv
// ----------------------------------------------------------------------------
// tsft_hash
// shortened one-at-a-time hash of address and port, reduced to a table index
// ----------------------------------------------------------------------------
module tsft_hash #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  tsft_pkg::hsh_key_t                 key,
  output logic                               done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   idx
);
  import tsft_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam bit          IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  logic [31:0] a1, a2, a3;
  logic [31:0] b1, b2, b3;
  logic [31:0] ha_r, hb_r;
  logic        va_r, vb_r;

  // first half: mix address, add port
  always_comb begin
    a1 = key.addr + (key.addr << 10);
    a2 = a1 ^ (a1 >> 6);
    a3 = a2 + {16'd0, key.port};
  end

  // second half: final avalanche
  always_comb begin
    b1 = ha_r + (ha_r << 3);
    b2 = b1 ^ (b1 >> 11);
    b3 = b2 + (b2 << 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= start;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) ha_r <= a3;
    if (va_r)  hb_r <= b3;
  end

  generate
    if (IS_POW2) begin : g_mask
      assign done = vb_r;
      assign idx  = hb_r[IDX_W-1:0];
    end else begin : g_rem
      // remainder by reciprocal multiplication; the quotient estimate is
      // low by at most one, so one compare and subtract finishes it
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);
      localparam logic [31:0] MOD_N = 32'(TABLE_ENTRIES);

      logic [63:0]      prod;
      logic [31:0]      diff;
      logic [31:0]      rem_full;
      logic [31:0]      quo_r;
      logic [31:0]      qn_r;
      logic [IDX_W-1:0] rem_r;
      logic             v1_r, v2_r, v3_r;

      always_comb begin
        prod     = {32'd0, hb_r} * {32'd0, RECIP};
        diff     = hb_r - qn_r;
        rem_full = (diff >= MOD_N) ? (diff - MOD_N) : diff;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r <= 1'b0;
          v2_r <= 1'b0;
          v3_r <= 1'b0;
        end else begin
          v1_r <= vb_r;
          v2_r <= v1_r;
          v3_r <= v2_r;
        end
      end

      always_ff @(posedge clk) begin
        if (vb_r) quo_r <= prod[63:32];
        if (v1_r) qn_r  <= quo_r * MOD_N;
        if (v2_r) rem_r <= rem_full[IDX_W-1:0];
      end

      assign done = v3_r;
      assign idx  = rem_r;
    end
  endgenerate

endmodule
